/* hw/rtl/pcl_pkg.sv */
// shared types, codes and helpers for the power command line parser
// used by pcl_csr, pcl_line and power_command_line_parser
package pcl_pkg;

   localparam int CharWidth  = 8;
   localparam int WordWidth  = 32;
   localparam int HoldWidth  = 16;
   localparam int PosWidth   = 4;
   localparam int IndexWidth = 3;

   localparam logic [PosWidth-1:0] NameLen = 4'd4;
   localparam logic [PosWidth-1:0] CmdLen  = 4'd12;

   localparam logic [HoldWidth-1:0] PowerOnHoldReset = 16'd500;
   localparam logic [HoldWidth-1:0] HaltHoldReset    = 16'd5500;

   // register indexes
   localparam logic [IndexWidth-1:0] RegPingWord    = 3'd0;
   localparam logic [IndexWidth-1:0] RegPowerOnWord = 3'd1;
   localparam logic [IndexWidth-1:0] RegHaltWord    = 3'd2;
   localparam logic [IndexWidth-1:0] RegResetWord   = 3'd3;
   localparam logic [IndexWidth-1:0] RegPowerOnHold = 3'd4;
   localparam logic [IndexWidth-1:0] RegHaltHold    = 3'd5;

   // status codes
   localparam logic [1:0] StatusOk          = 2'd0;
   localparam logic [1:0] StatusUnknown     = 2'd1;
   localparam logic [1:0] StatusInvalidArgs = 2'd2;

   // action codes
   localparam logic [1:0] ActionNone     = 2'd0;
   localparam logic [1:0] ActionPowerOn  = 2'd1;
   localparam logic [1:0] ActionHalt     = 2'd2;
   localparam logic [1:0] ActionResetCtl = 2'd3;

   typedef struct packed {
      logic [WordWidth-1:0] ping_word;
      logic [WordWidth-1:0] power_on_word;
      logic [WordWidth-1:0] halt_word;
      logic [WordWidth-1:0] reset_word;
      logic [HoldWidth-1:0] power_on_hold;
      logic [HoldWidth-1:0] halt_hold;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [1:0]           action;
      logic [WordWidth-1:0] output_mask;
      logic [HoldWidth-1:0] hold_time;
   } result_type;

   // bit 4 set when the character is a hex digit, low nibble is its value
   function automatic logic [4:0] hex_digit(input logic [CharWidth-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/power_command_line_parser.sv */
// top level of the power command line parser: config registers, line decode, result register
// depends on pcl_pkg, pcl_csr and pcl_line
//
// One character word is taken per clock while req_stall is low. Ordinary characters update
// the line state (name, hex digits, position); a zero byte is decoded in the same cycle and
// its result word appears on the rsp_ port in the next cycle from the result register.
// Sustained rate is one character per cycle; input stalls only while a result sits in the
// result register and the receiver stalls it. Config writes are always accepted (csr_ready
// is always high) and should be made while no command line is in progress.
module power_command_line_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pcl_pkg::CharWidth-1:0]  req_char_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_action,
   output logic [pcl_pkg::WordWidth-1:0]  rsp_output_mask,
   output logic [pcl_pkg::HoldWidth-1:0]  rsp_hold_time,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcl_pkg::IndexWidth-1:0] csr_index,
   input  logic [pcl_pkg::WordWidth-1:0]  csr_wdata
);

   pcl_pkg::cfg_type    cfg;
   pcl_pkg::result_type line_result;
   pcl_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_accept;
   logic                line_done;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   pcl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   pcl_line u_line (
      .clock   (clock),
      .reset   (reset),
      .char_en (req_accept),
      .char_in (req_char_in),
      .cfg     (cfg),
      .done    (line_done),
      .result  (line_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (line_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = line_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_action      = rsp_ff.action;
   assign rsp_output_mask = rsp_ff.output_mask;
   assign rsp_hold_time   = rsp_ff.hold_time;

endmodule

/* hw/rtl/pcl_csr.sv */
// configuration registers of the power command line parser
// depends on pcl_pkg
module pcl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [pcl_pkg::IndexWidth-1:0]  wr_index,
   input  logic [pcl_pkg::WordWidth-1:0]   wr_data,
   output pcl_pkg::cfg_type                cfg
);

   pcl_pkg::cfg_type cfg_ff;
   pcl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            pcl_pkg::RegPingWord:    cfg_in.ping_word     = wr_data;
            pcl_pkg::RegPowerOnWord: cfg_in.power_on_word = wr_data;
            pcl_pkg::RegHaltWord:    cfg_in.halt_word     = wr_data;
            pcl_pkg::RegResetWord:   cfg_in.reset_word    = wr_data;
            pcl_pkg::RegPowerOnHold:
               cfg_in.power_on_hold = wr_data[pcl_pkg::HoldWidth-1:0];
            pcl_pkg::RegHaltHold:
               cfg_in.halt_hold = wr_data[pcl_pkg::HoldWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_word     <= '0;
         cfg_ff.power_on_word <= '0;
         cfg_ff.halt_word     <= '0;
         cfg_ff.reset_word    <= '0;
         cfg_ff.power_on_hold <= pcl_pkg::PowerOnHoldReset;
         cfg_ff.halt_hold     <= pcl_pkg::HaltHoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/pcl_line.sv */
// line state and command decode of the power command line parser
// depends on pcl_pkg
module pcl_line (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           char_en,
   input  logic [pcl_pkg::CharWidth-1:0]  char_in,
   input  pcl_pkg::cfg_type               cfg,
   output logic                           done,
   output pcl_pkg::result_type            result
);

   logic [pcl_pkg::PosWidth-1:0]  char_position_ff, char_position_in;
   logic [pcl_pkg::WordWidth-1:0] name_shift_ff, name_shift_in;
   logic [pcl_pkg::WordWidth-1:0] hex_accumulator_ff, hex_accumulator_in;
   logic                          hex_error_ff, hex_error_in;
   logic [4:0]                    digit;
   logic                          terminator;
   logic                          hit_ping, hit_power_on, hit_halt, hit_reset;
   logic                          args_bad;

   assign digit      = pcl_pkg::hex_digit(char_in);
   assign terminator = (char_in == '0);
   assign done       = char_en && terminator;

   always_comb begin
      char_position_in   = char_position_ff;
      name_shift_in      = name_shift_ff;
      hex_accumulator_in = hex_accumulator_ff;
      hex_error_in       = hex_error_ff;
      if (char_en) begin
         if (terminator) begin
            char_position_in   = '0;
            name_shift_in      = '0;
            hex_accumulator_in = '0;
            hex_error_in       = 1'b0;
         end else if (char_position_ff < pcl_pkg::NameLen) begin
            name_shift_in    = {name_shift_ff[pcl_pkg::WordWidth-pcl_pkg::CharWidth-1:0],
                                char_in};
            char_position_in = char_position_ff + 1'b1;
         end else if (char_position_ff < pcl_pkg::CmdLen) begin
            if (digit[4]) begin
               hex_accumulator_in = {hex_accumulator_ff[pcl_pkg::WordWidth-5:0], digit[3:0]};
            end else begin
               hex_error_in = 1'b1;
            end
            char_position_in = char_position_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff   <= '0;
         name_shift_ff      <= '0;
         hex_accumulator_ff <= '0;
         hex_error_ff       <= 1'b0;
      end else begin
         char_position_ff   <= char_position_in;
         name_shift_ff      <= name_shift_in;
         hex_accumulator_ff <= hex_accumulator_in;
         hex_error_ff       <= hex_error_in;
      end
   end

   // decode of the finished line
   assign hit_ping     = (name_shift_ff == cfg.ping_word);
   assign hit_power_on = (name_shift_ff == cfg.power_on_word);
   assign hit_halt     = (name_shift_ff == cfg.halt_word);
   assign hit_reset    = (name_shift_ff == cfg.reset_word);
   assign args_bad     = (char_position_ff < pcl_pkg::CmdLen) || hex_error_ff;

   always_comb begin
      result.status      = pcl_pkg::StatusUnknown;
      result.action      = pcl_pkg::ActionNone;
      result.output_mask = '0;
      result.hold_time   = '0;
      if (char_position_ff >= pcl_pkg::NameLen) begin
         if (hit_ping) begin
            result.status = pcl_pkg::StatusOk;
         end else if (hit_power_on || hit_halt) begin
            if (args_bad) begin
               result.status = pcl_pkg::StatusInvalidArgs;
            end else begin
               result.status      = pcl_pkg::StatusOk;
               result.output_mask = hex_accumulator_ff;
               if (hit_power_on) begin
                  result.action    = pcl_pkg::ActionPowerOn;
                  result.hold_time = cfg.power_on_hold;
               end else begin
                  result.action    = pcl_pkg::ActionHalt;
                  result.hold_time = cfg.halt_hold;
               end
            end
         end else if (hit_reset) begin
            result.status = pcl_pkg::StatusOk;
            result.action = pcl_pkg::ActionResetCtl;
         end
      end
   end

endmodule

/* tb/power_command_line_parser_test.sv */
// self-checking testbench for power_command_line_parser: directed and random command lines
// a scoreboard class predicts each result word from the accepted characters; needs pcl_pkg

function automatic int digit_of(input logic [7:0] c);
   if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
   if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
   if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
   return -1;
endfunction

class command_line_tracker;
   logic [pcl_pkg::WordWidth-1:0] word_ping, word_power_on, word_halt, word_reset;
   logic [pcl_pkg::HoldWidth-1:0] hold_power_on, hold_halt;
   logic [pcl_pkg::PosWidth-1:0]  position;
   logic [pcl_pkg::WordWidth-1:0] name_bytes;
   logic [pcl_pkg::WordWidth-1:0] mask_digits;
   bit                            digit_fault;
   pcl_pkg::result_type           pending_results[$];

   function new();
      word_ping     = '0;
      word_power_on = '0;
      word_halt     = '0;
      word_reset    = '0;
      hold_power_on = pcl_pkg::PowerOnHoldReset;
      hold_halt     = pcl_pkg::HaltHoldReset;
      clear_line();
   endfunction

   function void clear_line();
      position    = '0;
      name_bytes  = '0;
      mask_digits = '0;
      digit_fault = 1'b0;
   endfunction

   function void set_reg(input logic [pcl_pkg::IndexWidth-1:0] index,
                         input logic [pcl_pkg::WordWidth-1:0] data);
      case (index)
         pcl_pkg::RegPingWord:    word_ping     = data;
         pcl_pkg::RegPowerOnWord: word_power_on = data;
         pcl_pkg::RegHaltWord:    word_halt     = data;
         pcl_pkg::RegResetWord:   word_reset    = data;
         pcl_pkg::RegPowerOnHold: hold_power_on = data[pcl_pkg::HoldWidth-1:0];
         pcl_pkg::RegHaltHold:    hold_halt     = data[pcl_pkg::HoldWidth-1:0];
         default: ;
      endcase
   endfunction

   function void take_char(input logic [pcl_pkg::CharWidth-1:0] c);
      int d;
      pcl_pkg::result_type r;
      if (c != 0) begin
         if (position < pcl_pkg::NameLen) begin
            name_bytes = {name_bytes[23:0], c};
         end else if (position < pcl_pkg::CmdLen) begin
            d = digit_of(c);
            if (d < 0) begin
               digit_fault = 1'b1;
            end else begin
               mask_digits = {mask_digits[27:0], 4'(d)};
            end
         end
         if (position < pcl_pkg::CmdLen) begin
            position = position + 1'b1;
         end
         return;
      end
      r.status      = pcl_pkg::StatusUnknown;
      r.action      = pcl_pkg::ActionNone;
      r.output_mask = '0;
      r.hold_time   = '0;
      if (position >= pcl_pkg::NameLen) begin
         if (name_bytes == word_ping) begin
            r.status = pcl_pkg::StatusOk;
         end else if (name_bytes == word_power_on || name_bytes == word_halt) begin
            if (position < pcl_pkg::CmdLen || digit_fault) begin
               r.status = pcl_pkg::StatusInvalidArgs;
            end else begin
               r.status      = pcl_pkg::StatusOk;
               r.output_mask = mask_digits;
               if (name_bytes == word_power_on) begin
                  r.action    = pcl_pkg::ActionPowerOn;
                  r.hold_time = hold_power_on;
               end else begin
                  r.action    = pcl_pkg::ActionHalt;
                  r.hold_time = hold_halt;
               end
            end
         end else if (name_bytes == word_reset) begin
            r.status = pcl_pkg::StatusOk;
            r.action = pcl_pkg::ActionResetCtl;
         end
      end
      pending_results.push_back(r);
      clear_line();
   endfunction

   function int match_result(input pcl_pkg::result_type got, output string why);
      pcl_pkg::result_type want;
      string fields;
      if (pending_results.size() == 0) begin
         why = $sformatf("unexpected word status %0d action %0d mask %h hold %0d",
                         got.status, got.action, got.output_mask, got.hold_time);
         return 1;
      end
      want = pending_results.pop_front();
      fields = "";
      if (got.status != want.status) fields = {fields, " status"};
      if (got.action != want.action) fields = {fields, " action"};
      if (got.output_mask != want.output_mask) fields = {fields, " output_mask"};
      if (got.hold_time != want.hold_time) fields = {fields, " hold_time"};
      if (fields == "") return 0;
      why = $sformatf("wrong%s: got %0d/%0d/%h/%0d want %0d/%0d/%h/%0d", fields,
                      got.status, got.action, got.output_mask, got.hold_time,
                      want.status, want.action, want.output_mask, want.hold_time);
      return 1;
   endfunction
endclass

module power_command_line_parser_test;

   typedef enum {
      LinePing, LinePowerOn, LineHalt, LineReset,
      LineBadDigit, LineMissing, LineShort, LineNoise
   } line_kind_type;

   localparam int SettleCycles = 4;
   localparam int TotalChars   = 1650;
   localparam int PhaseChars   = 270;
   localparam int IndexBits    = pcl_pkg::IndexWidth;
   localparam int HoldBits     = pcl_pkg::HoldWidth;

   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_valid       = 1'b0;
   logic                             req_stall;
   logic [pcl_pkg::CharWidth-1:0]    req_char_in     = '0;
   logic                             rsp_valid;
   logic                             rsp_stall       = 1'b0;
   logic [1:0]                       rsp_status;
   logic [1:0]                       rsp_action;
   logic [pcl_pkg::WordWidth-1:0]    rsp_output_mask;
   logic [pcl_pkg::HoldWidth-1:0]    rsp_hold_time;
   logic                             csr_valid       = 1'b0;
   logic                             csr_ready;
   logic [pcl_pkg::IndexWidth-1:0]   csr_index       = '0;
   logic [pcl_pkg::WordWidth-1:0]    csr_wdata       = '0;

   command_line_tracker tracker = new();
   int  mismatches        = 0;
   int  sent_chars        = 0;
   int  burst_left        = 0;
   bit  long_hold_request = 1'b0;
   int  hold_left         = 0;
   int  stall_mode        = 0;
   int  mode_left         = 0;
   int  stall_tick        = 0;

   power_command_line_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_action      (rsp_action),
      .rsp_output_mask (rsp_output_mask),
      .rsp_hold_time   (rsp_hold_time),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      string why;
      pcl_pkg::result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status      = rsp_status;
         got.action      = rsp_action;
         got.output_mask = rsp_output_mask;
         got.hold_time   = rsp_hold_time;
         if (tracker.match_result(got, why) != 0) report(why);
      end
   end

   // receiver stall pattern, with one long hold-off at the start of the second random phase
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         stall_tick++;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick % 5 < 2);
         endcase
      end
   end

   task automatic send_char(input logic [pcl_pkg::CharWidth-1:0] c);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_char(c);
      sent_chars++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_word(input logic [pcl_pkg::WordWidth-1:0] w);
      for (int i = 3; i >= 0; i--) send_char(w[8*i +: 8]);
   endtask

   task automatic send_noise(input int n);
      repeat (n) send_char(8'($urandom_range(1, 255)));
   endtask

   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   task automatic send_digits(input int n);
      repeat (n) send_char(hex_char());
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(8'h00);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending_results.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [pcl_pkg::IndexWidth-1:0] index,
                            input logic [pcl_pkg::WordWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(index, data);
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [pcl_pkg::WordWidth-1:0] ping, pwr, hlt, rst,
                               input logic [pcl_pkg::HoldWidth-1:0] pwr_hold, hlt_hold);
      wait_for_results();
      write_reg(pcl_pkg::RegPingWord, ping);
      write_reg(pcl_pkg::RegPowerOnWord, pwr);
      write_reg(pcl_pkg::RegHaltWord, hlt);
      write_reg(pcl_pkg::RegResetWord, rst);
      write_reg(pcl_pkg::RegPowerOnHold, {HoldBits'($urandom_range(0, 65535)), pwr_hold});
      write_reg(pcl_pkg::RegHaltHold, {HoldBits'($urandom_range(0, 65535)), hlt_hold});
      // indexes past the last register must be ignored
      write_reg(IndexBits'($urandom_range(6, 7)), $urandom());
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [pcl_pkg::WordWidth-1:0] pick_word();
      logic [pcl_pkg::WordWidth-1:0] w;
      case ($urandom_range(0, 7))
         0: w = $urandom();
         1: w = '1;
         2: w = 32'h01010101;
         3: w = '0;
         default: begin
            for (int i = 0; i < 4; i++) w[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
         end
      endcase
      return w;
   endfunction

   function automatic logic [pcl_pkg::HoldWidth-1:0] pick_hold();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return HoldBits'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic apply_random_config();
      logic [pcl_pkg::WordWidth-1:0] words[4];
      for (int i = 0; i < 4; i++) words[i] = pick_word();
      if ($urandom_range(0, 2) == 0) words[$urandom_range(1, 3)] = words[$urandom_range(0, 3)];
      apply_config(words[0], words[1], words[2], words[3], pick_hold(), pick_hold());
   endtask

   task automatic send_random_line();
      line_kind_type kind;
      logic [pcl_pkg::WordWidth-1:0] w;
      int pick, bad;
      logic [7:0] c;
      pick = $urandom_range(0, 11);
      if (pick <= 7) kind = line_kind_type'(pick);
      else kind = pick[0] ? LinePowerOn : LineHalt;
      w = $urandom_range(0, 1) ? tracker.word_power_on : tracker.word_halt;
      case (kind)
         LinePing: begin
            send_word(tracker.word_ping);
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 10));
         end
         LinePowerOn, LineHalt: begin
            send_word(kind == LinePowerOn ? tracker.word_power_on : tracker.word_halt);
            send_digits(8);
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
         end
         LineReset: begin
            send_word(tracker.word_reset);
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 10));
         end
         LineBadDigit: begin
            send_word(w);
            bad = $urandom_range(0, 7);
            for (int i = 0; i < 8; i++) begin
               if (i == bad) begin
                  do c = 8'($urandom_range(1, 255)); while (digit_of(c) >= 0);
                  send_char(c);
               end else begin
                  send_char(hex_char());
               end
            end
         end
         LineMissing: begin
            send_word(w);
            send_digits($urandom_range(0, 7));
         end
         LineShort: send_noise($urandom_range(0, 3));
         default: send_noise($urandom_range(4, 16));
      endcase
      send_char(8'h00);
   endtask

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int phase_start;
      int phase;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: no word can match
      send_text("ABCD");
      send_text("");

      apply_config("PING", "PWON", "HALT", "RSET", 16'd1234, 16'hFFFF);
      send_text("PING");
      send_text("PWON9AbFfe07");
      send_text("HALTFFFFFFFFxyz");
      send_text("HALT00000000");
      send_text("RSET");
      send_text("PWON12G45678");
      send_text("HALT123");
      send_text("PI");
      send_text("ZZZZ");

      // overlapping words: earlier word in the priority order wins
      apply_config("SAME", "DUPE", "DUPE", "SAME", 16'd0, 16'd0);
      send_text("SAME");
      send_text("DUPEa1B2c3D4");

      phase = 0;
      while (sent_chars < TotalChars) begin
         apply_random_config();
         phase_start = sent_chars;
         while (sent_chars < phase_start + PhaseChars && sent_chars < TotalChars) begin
            if (phase == 1 && sent_chars == phase_start) long_hold_request = 1'b1;
            send_random_line();
            if ($urandom_range(0, 40) == 0) wait_for_results();
         end
         phase++;
      end

      wait_for_results();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
